### hdl/gmr_pkg.sv
// Shared types and constants for the grid midpoint refiner.
package gmr_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_SCAN   = 2'd2;

  localparam logic [2:0] KIND_MID      = 3'd0;
  localparam logic [2:0] KIND_INSERTED = 3'd1;
  localparam logic [2:0] KIND_DUP      = 3'd2;
  localparam logic [2:0] KIND_PFULL    = 3'd3;
  localparam logic [2:0] KIND_SCANNED  = 3'd4;
  localparam logic [2:0] KIND_NOMORE   = 3'd5;
  localparam logic [2:0] KIND_CLEARED  = 3'd6;
  localparam logic [2:0] KIND_MDROP    = 3'd7;

  localparam logic [1:0] TGT_IN  = 2'd0;
  localparam logic [1:0] TGT_NB  = 2'd1;
  localparam logic [1:0] TGT_MID = 2'd2;

  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  localparam int NUM_PROBES = 9;
  localparam logic [3:0] LAST_PROBE = 4'd8;

  localparam logic [1:0] DIR_X [NUM_PROBES] = '{DIR_POS, DIR_ZERO, DIR_ZERO,
    DIR_POS, DIR_POS, DIR_POS, DIR_POS, DIR_ZERO, DIR_ZERO};
  localparam logic [1:0] DIR_Y [NUM_PROBES] = '{DIR_ZERO, DIR_POS, DIR_ZERO,
    DIR_POS, DIR_NEG, DIR_ZERO, DIR_ZERO, DIR_POS, DIR_POS};
  localparam logic [1:0] DIR_Z [NUM_PROBES] = '{DIR_ZERO, DIR_ZERO, DIR_POS,
    DIR_ZERO, DIR_ZERO, DIR_POS, DIR_NEG, DIR_POS, DIR_NEG};

  typedef struct packed {
    logic       latch_in;
    logic       tgt_load;
    logic [1:0] tgt_sel;
    logic       srch_start;
    logic       srch_mid;
    logic       rd_cursor;
    logic       latch_p;
    logic       pt_write;
    logic       mid_write;
    logic       clear;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_last;
    logic       emit_mid;
    logic [3:0] probe;
  } gmr_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic srch_found;
    logic scan_end;
    logic pt_full;
    logic mid_full;
    logic out_free;
  } gmr_stat_t;

endpackage

### hdl/gmr_ctrl.sv
// Sequencing state machine for the grid midpoint refiner.
module gmr_ctrl
  import gmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_stall,
  input  gmr_stat_t  stat,
  output gmr_cmd_t   cmd
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_INS_WAIT  = 4'd1;
  localparam logic [3:0] ST_CUR_LATCH = 4'd2;
  localparam logic [3:0] ST_NB        = 4'd3;
  localparam logic [3:0] ST_NB_WAIT   = 4'd4;
  localparam logic [3:0] ST_MP_WAIT   = 4'd5;
  localparam logic [3:0] ST_MM_WAIT   = 4'd6;
  localparam logic [3:0] ST_EMIT      = 4'd7;
  localparam logic [3:0] ST_NEXT      = 4'd8;

  logic [3:0] state, state_next;
  logic [3:0] probe, probe_next;
  logic [2:0] kind, kind_next;
  logic       last, last_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      probe <= '0;
      kind  <= KIND_MID;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      probe <= probe_next;
      kind  <= kind_next;
      last  <= last_next;
    end
  end

  always_comb begin
    state_next = state;
    probe_next = probe;
    kind_next  = kind;
    last_next  = last;
    cmd        = '0;
    cmd.probe  = probe;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          priority case (req_type)
            REQ_INSERT: begin
              cmd.tgt_load   = 1'b1;
              cmd.tgt_sel    = TGT_IN;
              cmd.srch_start = 1'b1;
              state_next     = ST_INS_WAIT;
            end
            REQ_CLEAR: begin
              cmd.clear  = 1'b1;
              kind_next  = KIND_CLEARED;
              last_next  = 1'b1;
              state_next = ST_EMIT;
            end
            REQ_SCAN: begin
              if (stat.scan_end) begin
                kind_next  = KIND_NOMORE;
                last_next  = 1'b1;
                state_next = ST_EMIT;
              end else begin
                cmd.rd_cursor = 1'b1;
                state_next    = ST_CUR_LATCH;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_WAIT: begin
        if (stat.srch_done) begin
          last_next  = 1'b1;
          state_next = ST_EMIT;
          if (stat.srch_found)   kind_next = KIND_DUP;
          else if (stat.pt_full) kind_next = KIND_PFULL;
          else                   kind_next = KIND_INSERTED;
        end
      end
      ST_CUR_LATCH: begin
        cmd.latch_p = 1'b1;
        probe_next  = '0;
        state_next  = ST_NB;
      end
      ST_NB: begin
        cmd.tgt_load   = 1'b1;
        cmd.tgt_sel    = TGT_NB;
        cmd.srch_start = 1'b1;
        state_next     = ST_NB_WAIT;
      end
      ST_NB_WAIT: begin
        if (stat.srch_done) begin
          if (stat.srch_found) begin
            cmd.tgt_load   = 1'b1;
            cmd.tgt_sel    = TGT_MID;
            cmd.srch_start = 1'b1;
            state_next     = ST_MP_WAIT;
          end else begin
            state_next = ST_NEXT;
          end
        end
      end
      ST_MP_WAIT: begin
        if (stat.srch_done) begin
          if (stat.srch_found) begin
            state_next = ST_NEXT;
          end else begin
            cmd.srch_start = 1'b1;
            cmd.srch_mid   = 1'b1;
            state_next     = ST_MM_WAIT;
          end
        end
      end
      ST_MM_WAIT: begin
        if (stat.srch_done) begin
          if (stat.srch_found) begin
            state_next = ST_NEXT;
          end else begin
            kind_next  = stat.mid_full ? KIND_MDROP : KIND_MID;
            last_next  = 1'b0;
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = kind;
          cmd.emit_last = last;
          cmd.emit_mid  = (kind == KIND_MID) || (kind == KIND_MDROP);
          cmd.mid_write = (kind == KIND_MID);
          cmd.pt_write  = (kind == KIND_INSERTED);
          state_next    = last ? ST_IDLE : ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (probe == LAST_PROBE) begin
          kind_next  = KIND_SCANNED;
          last_next  = 1'b1;
          state_next = ST_EMIT;
        end else begin
          probe_next = probe + 4'd1;
          state_next = ST_NB;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/gmr_dp.sv
// Datapath: point and midpoint memories, search unit, probe arithmetic, result register.
module gmr_dp
  import gmr_pkg::*;
#(
  parameter int POINT_CAPACITY = 1024,
  parameter int MID_CAPACITY   = 4096,
  parameter int COORD_BITS     = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gmr_cmd_t                     cmd,
  output gmr_stat_t                    stat,
  input  logic [16:0]                  spacing,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   kind,
  output logic signed [COORD_BITS-1:0] mid_x,
  output logic signed [COORD_BITS-1:0] mid_y,
  output logic signed [COORD_BITS-1:0] mid_z,
  output logic                         last_of_run
);

  localparam int CW  = COORD_BITS;
  localparam int WW  = ((CW > 17) ? CW : 17) + 2;
  localparam int PAW = $clog2(POINT_CAPACITY);
  localparam int PCW = $clog2(POINT_CAPACITY + 1);
  localparam int MAW = $clog2(MID_CAPACITY);
  localparam int MCW = $clog2(MID_CAPACITY + 1);
  localparam int IW  = (PCW > MCW) ? PCW : MCW;
  localparam int EW  = 3 * CW;

  logic [EW-1:0] pt_mem  [POINT_CAPACITY];
  logic [EW-1:0] mid_mem [MID_CAPACITY];
  logic [EW-1:0] pt_rdata, mid_rdata;

  logic [PCW-1:0] point_count, scan_cursor;
  logic [MCW-1:0] mid_count;

  logic [CW-1:0] in_x, in_y, in_z;
  logic [CW-1:0] p_x, p_y, p_z;
  logic signed [WW-1:0] tgt_x, tgt_y, tgt_z;

  logic          srch_run, srch_mid_r, rv;
  logic [IW-1:0] idx, limit;
  logic          issue, hit;
  logic [EW-1:0] rsel;

  function automatic logic signed [WW-1:0] sx(input logic [CW-1:0] v);
    sx = {{(WW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [WW-1:0] offs(input logic [1:0] d,
                                                input logic [16:0] sp);
    logic signed [WW-1:0] s;
    s = {{(WW-17){1'b0}}, sp};
    unique case (d)
      DIR_POS: offs = s;
      DIR_NEG: offs = -s;
      default: offs = '0;
    endcase
  endfunction

  function automatic logic signed [WW-1:0] halve(input logic signed [WW-1:0] a,
                                                 input logic signed [WW-1:0] b);
    logic signed [WW:0] sum, h;
    sum = {a[WW-1], a} + {b[WW-1], b};
    h   = sum >>> 1;
    if (sum[WW] && sum[0]) h = h + 1'b1;
    halve = h[WW-1:0];
  endfunction

  logic signed [WW-1:0] nb_x, nb_y, nb_z;
  assign nb_x = sx(p_x) + offs(DIR_X[cmd.probe], spacing);
  assign nb_y = sx(p_y) + offs(DIR_Y[cmd.probe], spacing);
  assign nb_z = sx(p_z) + offs(DIR_Z[cmd.probe], spacing);

  // Search unit: stream one entry per cycle, compare each in the cycle after it is read.
  assign limit = srch_mid_r ? IW'(mid_count) : IW'(point_count);
  assign issue = srch_run && (idx < limit);
  assign rsel  = srch_mid_r ? mid_rdata : pt_rdata;
  assign hit   = srch_run && rv &&
                 (sx(rsel[CW-1:0]) == tgt_x) &&
                 (sx(rsel[2*CW-1:CW]) == tgt_y) &&
                 (sx(rsel[3*CW-1:2*CW]) == tgt_z);

  assign stat.srch_done  = srch_run && (hit || (!issue && !rv));
  assign stat.srch_found = hit;
  assign stat.scan_end   = (scan_cursor >= point_count);
  assign stat.pt_full    = (point_count >= PCW'(POINT_CAPACITY));
  assign stat.mid_full   = (mid_count >= MCW'(MID_CAPACITY));
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.pt_write) pt_mem[point_count[PAW-1:0]] <= {in_z, in_y, in_x};
    if (cmd.rd_cursor) pt_rdata <= pt_mem[scan_cursor[PAW-1:0]];
    else if (issue && !srch_mid_r) pt_rdata <= pt_mem[idx[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.mid_write) mid_mem[mid_count[MAW-1:0]] <= {tgt_z[CW-1:0], tgt_y[CW-1:0],
                                                       tgt_x[CW-1:0]};
    if (issue && srch_mid_r) mid_rdata <= mid_mem[idx[MAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srch_run    <= 1'b0;
      srch_mid_r  <= 1'b0;
      rv          <= 1'b0;
      idx         <= '0;
      point_count <= '0;
      mid_count   <= '0;
      scan_cursor <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.srch_start) begin
        srch_run   <= 1'b1;
        srch_mid_r <= cmd.srch_mid;
        rv         <= 1'b0;
        idx        <= '0;
      end else if (stat.srch_done) begin
        srch_run <= 1'b0;
        rv       <= 1'b0;
      end else if (srch_run) begin
        rv <= issue;
        if (issue) idx <= idx + 1'b1;
      end
      if (cmd.clear) begin
        point_count <= '0;
        mid_count   <= '0;
        scan_cursor <= '0;
      end else begin
        if (cmd.pt_write)  point_count <= point_count + 1'b1;
        if (cmd.mid_write) mid_count   <= mid_count + 1'b1;
        if (cmd.latch_p)   scan_cursor <= scan_cursor + 1'b1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_x <= point_x;
      in_y <= point_y;
      in_z <= point_z;
    end
    if (cmd.latch_p) begin
      p_x <= pt_rdata[CW-1:0];
      p_y <= pt_rdata[2*CW-1:CW];
      p_z <= pt_rdata[3*CW-1:2*CW];
    end
    if (cmd.tgt_load) begin
      unique case (cmd.tgt_sel)
        TGT_IN: begin
          tgt_x <= sx(point_x);
          tgt_y <= sx(point_y);
          tgt_z <= sx(point_z);
        end
        TGT_NB: begin
          tgt_x <= nb_x;
          tgt_y <= nb_y;
          tgt_z <= nb_z;
        end
        default: begin
          tgt_x <= halve(sx(p_x), tgt_x);
          tgt_y <= halve(sx(p_y), tgt_y);
          tgt_z <= halve(sx(p_z), tgt_z);
        end
      endcase
    end
    if (cmd.emit) begin
      kind        <= cmd.emit_kind;
      last_of_run <= cmd.emit_last;
      mid_x       <= cmd.emit_mid ? tgt_x[CW-1:0] : '0;
      mid_y       <= cmd.emit_mid ? tgt_y[CW-1:0] : '0;
      mid_z       <= cmd.emit_mid ? tgt_z[CW-1:0] : '0;
    end
  end

endmodule

### hdl/grid_midpoint_refiner.sv
// Top level of the grid midpoint refiner: APB register, controller and datapath.
// Acceptance to result register: insert and scan time is set by the linear memory
//   searches, a clear runs no search, and the result channel can stall any of them.
// Throughput: one transaction at a time; the next is taken once the last result
//   of the current one is in the output register.
// Reset (rst, synchronous): counts and cursor cleared, spacing 1000, no result
//   pending. Memory contents are not cleared.
module grid_midpoint_refiner
  import gmr_pkg::*;
#(
  parameter int POINT_CAPACITY = 1024,
  parameter int MID_CAPACITY   = 4096,
  parameter int COORD_BITS     = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   kind,
  output logic signed [COORD_BITS-1:0] mid_x,
  output logic signed [COORD_BITS-1:0] mid_y,
  output logic signed [COORD_BITS-1:0] mid_z,
  output logic                         last_of_run
);

  localparam logic [16:0] SPACING_RESET = 17'd1000;

  logic [16:0] spacing;
  gmr_cmd_t    cmd;
  gmr_stat_t   stat;

  // Spacing register sits at byte address 0; other addresses read zero.
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {15'd0, spacing} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      spacing <= pwdata[16:0];
    end
  end

  // Controller steps each transaction: clear, insert search, or scan load followed
  // by nine probes, each probe a neighbor search and, if it hits, a midpoint search
  // over the points and then, if not found there, over the recorded midpoints.
  gmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gmr_dp #(
    .POINT_CAPACITY (POINT_CAPACITY),
    .MID_CAPACITY   (MID_CAPACITY),
    .COORD_BITS     (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .spacing     (spacing),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .mid_x       (mid_x),
    .mid_y       (mid_y),
    .mid_z       (mid_z),
    .last_of_run (last_of_run)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the grid midpoint refiner.
`timescale 1ns / 1ps

module testbench
  import gmr_pkg::*;
();

  localparam int PT_CAP  = 1024;
  localparam int MID_CAP = 4096;
  localparam int LIMIT   = 20000000;
  localparam logic [2:0] ADDR_SPACING = 3'd0;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  typedef struct {
    logic [1:0]         req;
    logic signed [23:0] x, y, z;
  } request_t;

  typedef struct {
    logic [2:0]         kind;
    logic signed [23:0] x, y, z;
    logic               last;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = REQ_INSERT;
  logic signed [23:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] kind;
  logic signed [23:0] mid_x, mid_y, mid_z;
  logic last_of_run;

  grid_midpoint_refiner uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state: its own copy of the stores and the spacing register.
  logic signed [23:0] pts [PT_CAP][3];
  logic signed [23:0] mids [MID_CAP][3];
  int pt_cnt = 0, mid_cnt = 0, cursor = 0;
  logic [16:0] spacing = 17'd1000;

  request_t     pending_reqs[$];
  grid_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;      // end of run: no idling on either side
  bit hold_in = 1'b0;    // stimulus hold-off until the block drains
  int in_gap = 0, out_gap = 0;

  function automatic bit point_known(logic signed [24:0] c[3]);
    for (int i = 0; i < pt_cnt; i++)
      if (pts[i][0] == c[0] && pts[i][1] == c[1] && pts[i][2] == c[2]) return 1;
    return 0;
  endfunction

  function automatic bit mid_known(logic signed [24:0] c[3]);
    for (int i = 0; i < mid_cnt; i++)
      if (mids[i][0] == c[0] && mids[i][1] == c[1] && mids[i][2] == c[2]) return 1;
    return 0;
  endfunction

  function automatic void push_result(logic [2:0] k, logic signed [23:0] x,
                                      logic signed [23:0] y, logic signed [23:0] z,
                                      logic last);
    grid_result_t r;
    r.kind = k; r.x = x; r.y = y; r.z = z; r.last = last;
    expected_results = {expected_results, r};
  endfunction

  // Compute the results of one accepted transaction and advance the model state.
  function automatic void refine_request(request_t q);
    logic signed [24:0] p[3], nb[3], md[3];
    logic signed [25:0] sum;
    int dx[9] = '{1, 0, 0, 1, 1, 1, 1, 0, 0};
    int dy[9] = '{0, 1, 0, 1, -1, 0, 0, 1, 1};
    int dz[9] = '{0, 0, 1, 0, 0, 1, -1, 1, -1};
    unique case (q.req)
      REQ_INSERT: begin
        p[0] = q.x; p[1] = q.y; p[2] = q.z;
        if (point_known(p)) push_result(KIND_DUP, 0, 0, 0, 1);
        else if (pt_cnt >= PT_CAP) push_result(KIND_PFULL, 0, 0, 0, 1);
        else begin
          pts[pt_cnt][0] = q.x; pts[pt_cnt][1] = q.y; pts[pt_cnt][2] = q.z;
          pt_cnt++;
          push_result(KIND_INSERTED, 0, 0, 0, 1);
        end
      end
      REQ_CLEAR: begin
        pt_cnt = 0; mid_cnt = 0; cursor = 0;
        push_result(KIND_CLEARED, 0, 0, 0, 1);
      end
      REQ_SCAN: begin
        if (cursor >= pt_cnt) begin
          push_result(KIND_NOMORE, 0, 0, 0, 1);
          return;
        end
        for (int a = 0; a < 3; a++) p[a] = pts[cursor][a];
        cursor++;
        for (int d = 0; d < 9; d++) begin
          int dir[3];
          dir[0] = dx[d]; dir[1] = dy[d]; dir[2] = dz[d];
          for (int a = 0; a < 3; a++) begin
            nb[a] = 25'(p[a] + dir[a] * $signed({1'b0, spacing}));
            sum = p[a] + nb[a];
            md[a] = 25'(sum / 26'sd2);   // truncates toward zero
          end
          // Drop neighbours that are not stored points; those outside the coordinate range never are.
          if (!point_known(nb)) continue;
          if (point_known(md) || mid_known(md)) continue;
          if (mid_cnt < MID_CAP) begin
            for (int a = 0; a < 3; a++) mids[mid_cnt][a] = 24'(md[a]);
            mid_cnt++;
            push_result(KIND_MID, 24'(md[0]), 24'(md[1]), 24'(md[2]), 0);
          end else push_result(KIND_MDROP, 24'(md[0]), 24'(md[1]), 24'(md[2]), 0);
        end
        push_result(KIND_SCANNED, 0, 0, 0, 1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_coord();
    unique case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'(24'sh7FFFFF - $urandom_range(0, 3) * 1000);
      2: return 24'(-24'sh800000 + $urandom_range(0, 3) * 1000);
      default: return 24'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic queue_request(logic [1:0] r, logic signed [23:0] x,
                               logic signed [23:0] y, logic signed [23:0] z);
    request_t q;
    q.req = r; q.x = x; q.y = y; q.z = z;
    pending_reqs = {pending_reqs, q};
  endtask

  // Write the spacing register while the block is idle.
  task automatic write_spacing(logic [16:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_SPACING; pwdata <= {15'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    spacing = v;
  endtask

  // Hold until every queued transaction is taken and every result is in.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Fill a small lattice at spacing s around a random corner.
  task automatic queue_lattice(int s, int n);
    int bx, by, bz;
    bx = $signed($urandom_range(0, 20000)) - 10000;
    by = $signed($urandom_range(0, 20000)) - 10000;
    bz = $signed($urandom_range(0, 20000)) - 10000;
    for (int i = 0; i < n; i++)
      queue_request(REQ_INSERT, 24'(bx + s * $urandom_range(0, 2)),
                    24'(by + s * $urandom_range(0, 2)),
                    24'(bz + s * $urandom_range(0, 2)));
  endtask

  initial begin
    int sp_list[4] = '{1, 7, 1000, 100000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicate, scans past the end, clear, reserved code.
    queue_request(REQ_SCAN, 0, 0, 0);
    queue_request(REQ_INSERT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_request(REQ_INSERT, -24'sh800000, -24'sh800000, -24'sh800000);
    queue_request(REQ_INSERT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_request(REQ_INSERT, -24'sh800000 + 1000, -24'sh800000, -24'sh800000);
    queue_request(REQ_INSERT, 0, 0, 0);
    queue_request(REQ_INSERT, 1000, 1000, 0);
    queue_request(REQ_INSERT, 1000, -1000, 0);
    queue_request(REQ_INSERT, -1001, 0, 0);
    queue_request(REQ_INSERT, -1, 0, 0);
    queue_request(REQ_UNUSED, 24'sh555555, -24'sh2AAAAB, 24'sh123456);
    for (int i = 0; i < 8; i++) queue_request(REQ_SCAN, 0, 0, 0);
    queue_request(REQ_CLEAR, 0, 0, 0);
    queue_request(REQ_SCAN, 0, 0, 0);
    drain();

    // Random phases over several spacings, from 1 to 100000.
    for (int ph = 0; ph < 4; ph++) begin
      write_spacing(17'(sp_list[ph]));
      if (ph == 2) hold_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
        queue_lattice(sp_list[ph], 14);
        if ($urandom_range(0, 1)) queue_request(REQ_INSERT, rand_coord(), rand_coord(),
                                                rand_coord());
        for (int i = 0; i < 12; i++) begin
          if ($urandom_range(0, 9) == 0)
            queue_request(2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                          rand_coord());
          queue_request(REQ_SCAN, 0, 0, 0);
        end
        if ($urandom_range(0, 2) == 0) queue_request(REQ_CLEAR, 0, 0, 0);
      end
      if (ph == 3) quiet = 1'b1;
      drain();
      hold_in = 1'b0;
    end
    write_spacing(17'd0);
    queue_lattice(5, 6);
    for (int i = 0; i < 4; i++) queue_request(REQ_SCAN, 0, 0, 0);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Driver: present the oldest pending transaction, idle in random bursts.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        refine_request(pending_reqs.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && !(hold_in && expected_results.size() != 0)
                   && !(in_valid && !in_stall && pending_reqs.size() == 0)) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          req_type <= pending_reqs[0].req;
          point_x <= pending_reqs[0].x;
          point_y <= pending_reqs[0].y;
          point_z <= pending_reqs[0].z;
        end
      end else in_valid <= 1'b0;
    end
  end

  // Monitor: compare each result with the oldest expectation; stall in bursts.
  always @(posedge clk) begin
    grid_result_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d", kind);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, kind); errors++;
          end
          if (mid_x !== e.x) begin
            $error("mid_x: expected %0d, got %0d", e.x, mid_x); errors++;
          end
          if (mid_y !== e.y) begin
            $error("mid_y: expected %0d, got %0d", e.y, mid_y); errors++;
          end
          if (mid_z !== e.z) begin
            $error("mid_z: expected %0d, got %0d", e.z, mid_z); errors++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run: expected %0d, got %0d", e.last, last_of_run);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

endmodule
